@@ sv/ufst_pkg.sv @@
// ----------------------------------------------------------------------------
// ufst_pkg
// Shared types and constants for the union-find spanning tree block.
// ----------------------------------------------------------------------------
package ufst_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int RANK_W       = 4;
  localparam int WGT_W        = 64;
  localparam int EW_W         = 32;

  localparam logic [RANK_W-1:0] RANK_LIMIT = RANK_W'(15);
  localparam logic [RANK_W-1:0] RANK_INIT  = RANK_W'(1);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(MAX_VERTICES);

  // register word index on the configuration port
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [WGT_W-1:0]  wgt_t;

  typedef struct packed {
    vidx_t                   vertex_a;
    vidx_t                   vertex_b;
    logic signed [EW_W-1:0]  edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                     joined;
    logic                     bad_vertex;
    cnt_t                     components_left;
    logic signed [WGT_W-1:0]  tree_weight;
  } out_item_t;

  // one entry of the link store: rank of the entry and its parent
  typedef struct packed {
    rank_t rank;
    vidx_t parent;
  } link_t;

  // access requests from the sequencer to the store
  typedef struct packed {
    logic  p_re;
    vidx_t p_raddr;
    logic  p_we;
    vidx_t p_waddr;
    link_t p_wdata;
    logic  w_re;
    vidx_t w_raddr;
    logic  w_we;
    vidx_t w_waddr;
    wgt_t  w_wdata;
  } store_req_t;

endpackage

@@ sv/union_find_spanning_tree_top.sv @@
// ----------------------------------------------------------------------------
// union_find_spanning_tree_top
// Kruskal join step on a union-find store, one edge per command.
// ----------------------------------------------------------------------------
// Sequence: a find walk reads one link per cycle, then writes one compression
//   per visited entry; walks for vertex_a and vertex_b (skipped for a bad vertex),
//   the union states S_UNI0..S_UNI3 when joined, a walk from vertex 0, S_RDW, S_DONE.
// Throughput: one edge at a time; busy drops in the cycle of the result strobe.
// Reset: a clearing sweep of all entries with busy high; a vertex_count write
//   while idle starts the same sweep. The result strobe lasts one cycle; no stall.
// ----------------------------------------------------------------------------
module union_find_spanning_tree_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ufst_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ufst_pkg::out_item_t  out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  ufst_pkg::store_req_t req;
  ufst_pkg::link_t      p_rdata;
  ufst_pkg::wgt_t       w_rdata;
  ufst_pkg::cnt_t       vertex_count;
  ufst_pkg::cnt_t       cfg_count;
  ufst_pkg::cnt_t       raw;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign raw    = pwdata[ufst_pkg::CNT_W-1:0];

  // clamp the written count into 1..MAX_VERTICES
  always_comb begin
    if (raw == '0) begin
      cfg_count = ufst_pkg::cnt_t'(1);
    end else if (raw > ufst_pkg::COUNT_MAX) begin
      cfg_count = ufst_pkg::COUNT_MAX;
    end else begin
      cfg_count = raw;
    end
  end

  assign cfg_we = psel && penable && pwrite && (paddr[2] == ufst_pkg::REG_VERTEX_COUNT);
  assign prdata = (paddr[2] == ufst_pkg::REG_VERTEX_COUNT) ?
                  {{(32-ufst_pkg::CNT_W){1'b0}}, vertex_count} : '0;

  ufst_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .item         (in_item),
    .cfg_we       (cfg_we),
    .cfg_count    (cfg_count),
    .p_rdata      (p_rdata),
    .w_rdata      (w_rdata),
    .req          (req),
    .busy         (busy),
    .vertex_count (vertex_count),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  ufst_store u_store (
    .clk     (clk),
    .req     (req),
    .p_rdata (p_rdata),
    .w_rdata (w_rdata)
  );

endmodule

@@ sv/ufst_store.sv @@
// ----------------------------------------------------------------------------
// ufst_store
// Link/rank memory and component weight memory, registered reads.
// ----------------------------------------------------------------------------
module ufst_store (
  input  logic                clk,
  input  ufst_pkg::store_req_t req,
  output ufst_pkg::link_t     p_rdata,
  output ufst_pkg::wgt_t      w_rdata
);

  ufst_pkg::link_t link_mem [ufst_pkg::MAX_VERTICES];
  ufst_pkg::wgt_t  wgt_mem  [ufst_pkg::MAX_VERTICES];

  // link memory port
  always_ff @(posedge clk) begin
    if (req.p_we) begin
      link_mem[req.p_waddr] <= req.p_wdata;
    end
    if (req.p_re) begin
      p_rdata <= link_mem[req.p_raddr];
    end
  end

  // weight memory port
  always_ff @(posedge clk) begin
    if (req.w_we) begin
      wgt_mem[req.w_waddr] <= req.w_wdata;
    end
    if (req.w_re) begin
      w_rdata <= wgt_mem[req.w_raddr];
    end
  end

endmodule

@@ sv/ufst_seq.sv @@
// ----------------------------------------------------------------------------
// ufst_seq
// Sequencer: clearing sweep, find walks with path compression, union update.
// ----------------------------------------------------------------------------
module ufst_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ufst_pkg::in_item_t    item,
  input  logic                  cfg_we,
  input  ufst_pkg::cnt_t        cfg_count,
  input  ufst_pkg::link_t       p_rdata,
  input  ufst_pkg::wgt_t        w_rdata,
  output ufst_pkg::store_req_t  req,
  output logic                  busy,
  output ufst_pkg::cnt_t        vertex_count,
  output logic                  out_valid,
  output ufst_pkg::out_item_t   out_item
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_FIND  = 10'b0000000100,
    S_COMP  = 10'b0000001000,
    S_UNI0  = 10'b0000010000,
    S_UNI1  = 10'b0000100000,
    S_UNI2  = 10'b0001000000,
    S_UNI3  = 10'b0010000000,
    S_RDW   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_A = 3'b001,
    PH_B = 3'b010,
    PH_Z = 3'b100
  } phase_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  ufst_pkg::vidx_t       cur_r, cur_nxt;
  ufst_pkg::vidx_t       walkv_r, walkv_nxt;
  ufst_pkg::vidx_t       root_r, root_nxt;
  ufst_pkg::rank_t       rootrk_r, rootrk_nxt;
  ufst_pkg::vidx_t       ra_r, ra_nxt;
  ufst_pkg::rank_t       rka_r, rka_nxt;
  ufst_pkg::vidx_t       win_r, win_nxt;
  ufst_pkg::vidx_t       lose_r, lose_nxt;
  ufst_pkg::rank_t       wrk_r, wrk_nxt;
  ufst_pkg::rank_t       lrk_r, lrk_nxt;
  logic                  eq_r, eq_nxt;
  ufst_pkg::wgt_t        acc_r, acc_nxt;
  ufst_pkg::cnt_t        total_r, total_nxt;
  ufst_pkg::cnt_t        vc_r, vc_nxt;
  ufst_pkg::vidx_t       clr_r, clr_nxt;
  ufst_pkg::in_item_t    item_r, item_nxt;
  logic                  joined_r, joined_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ov_r, ov_nxt;
  ufst_pkg::out_item_t   oi_r, oi_nxt;

  logic                  fin;
  ufst_pkg::vidx_t       rt;
  ufst_pkg::rank_t       rk;
  ufst_pkg::wgt_t        ew_ext;

  assign busy         = (state_r != S_IDLE);
  assign vertex_count = vc_r;
  assign out_valid    = ov_r;
  assign out_item     = oi_r;
  assign ew_ext = {{(ufst_pkg::WGT_W-ufst_pkg::EW_W){item_r.edge_weight[ufst_pkg::EW_W-1]}},
                   item_r.edge_weight};

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    walkv_nxt  = walkv_r;
    root_nxt   = root_r;
    rootrk_nxt = rootrk_r;
    ra_nxt     = ra_r;
    rka_nxt    = rka_r;
    win_nxt    = win_r;
    lose_nxt   = lose_r;
    wrk_nxt    = wrk_r;
    lrk_nxt    = lrk_r;
    eq_nxt     = eq_r;
    acc_nxt    = acc_r;
    total_nxt  = total_r;
    vc_nxt     = vc_r;
    clr_nxt    = clr_r;
    item_nxt   = item_r;
    joined_nxt = joined_r;
    bad_nxt    = bad_r;
    ov_nxt     = 1'b0;
    oi_nxt     = oi_r;
    req        = '0;
    fin        = 1'b0;
    rt         = root_r;
    rk         = rootrk_r;

    case (state_r)
      S_IDLE: begin
        // a new count sweeps the store back to identity; otherwise start accepts an edge
        if (cfg_we) begin
          vc_nxt    = cfg_count;
          total_nxt = cfg_count;
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end else if (start) begin
          item_nxt   = item;
          joined_nxt = 1'b0;
          bad_nxt    = ({1'b0, item.vertex_a} >= vc_r) || ({1'b0, item.vertex_b} >= vc_r);
          phase_nxt  = PH_A;
          cur_nxt    = item.vertex_a;
          walkv_nxt  = item.vertex_a;
          if (({1'b0, item.vertex_a} >= vc_r) || ({1'b0, item.vertex_b} >= vc_r)) begin
            phase_nxt = PH_Z;
            cur_nxt   = '0;
            walkv_nxt = '0;
          end
          req.p_re    = 1'b1;
          req.p_raddr = cur_nxt;
          state_nxt   = S_FIND;
        end
      end
      S_CLEAR: begin
        req.p_we    = 1'b1;
        req.p_waddr = clr_r;
        req.p_wdata = '{rank: ufst_pkg::RANK_INIT, parent: clr_r};
        req.w_we    = 1'b1;
        req.w_waddr = clr_r;
        req.w_wdata = '0;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == ufst_pkg::vidx_t'(ufst_pkg::MAX_VERTICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIND: begin
        // advance one link per cycle until an entry points at itself
        if (p_rdata.parent == cur_r) begin
          root_nxt   = cur_r;
          rootrk_nxt = p_rdata.rank;
          if (walkv_r == cur_r) begin
            fin = 1'b1;
            rt  = cur_r;
            rk  = p_rdata.rank;
          end else begin
            cur_nxt     = walkv_r;
            req.p_re    = 1'b1;
            req.p_raddr = walkv_r;
            state_nxt   = S_COMP;
          end
        end else begin
          cur_nxt     = p_rdata.parent;
          req.p_re    = 1'b1;
          req.p_raddr = p_rdata.parent;
        end
      end
      S_COMP: begin
        // point the visited entry straight at the root, keep its rank
        req.p_we    = 1'b1;
        req.p_waddr = cur_r;
        req.p_wdata = '{rank: p_rdata.rank, parent: root_r};
        if (p_rdata.parent == root_r) begin
          fin = 1'b1;
        end else begin
          cur_nxt     = p_rdata.parent;
          req.p_re    = 1'b1;
          req.p_raddr = p_rdata.parent;
        end
      end
      S_UNI0: begin
        req.p_we    = 1'b1;
        req.p_waddr = lose_r;
        req.p_wdata = '{rank: lrk_r, parent: win_r};
        req.w_re    = 1'b1;
        req.w_raddr = win_r;
        state_nxt   = S_UNI1;
      end
      S_UNI1: begin
        if (eq_r && (wrk_r < ufst_pkg::RANK_LIMIT)) begin
          req.p_we    = 1'b1;
          req.p_waddr = win_r;
          req.p_wdata = '{rank: wrk_r + 1'b1, parent: win_r};
        end
        acc_nxt     = w_rdata + ew_ext;
        req.w_re    = 1'b1;
        req.w_raddr = lose_r;
        state_nxt   = S_UNI2;
      end
      S_UNI2: begin
        acc_nxt   = acc_r + w_rdata;
        state_nxt = S_UNI3;
      end
      S_UNI3: begin
        req.w_we    = 1'b1;
        req.w_waddr = win_r;
        req.w_wdata = acc_r;
        if (total_r > ufst_pkg::cnt_t'(1)) begin
          total_nxt = total_r - 1'b1;
        end
        joined_nxt  = 1'b1;
        phase_nxt   = PH_Z;
        cur_nxt     = '0;
        walkv_nxt   = '0;
        req.p_re    = 1'b1;
        req.p_raddr = '0;
        state_nxt   = S_FIND;
      end
      S_RDW: begin
        req.w_re    = 1'b1;
        req.w_raddr = root_r;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        oi_nxt    = '{joined: joined_r, bad_vertex: bad_r,
                      components_left: total_r, tree_weight: w_rdata};
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hand the found root to the next step of the item
    if (fin) begin
      case (phase_r)
        PH_A: begin
          ra_nxt      = rt;
          rka_nxt     = rk;
          phase_nxt   = PH_B;
          cur_nxt     = item_r.vertex_b;
          walkv_nxt   = item_r.vertex_b;
          req.p_re    = 1'b1;
          req.p_raddr = item_r.vertex_b;
          state_nxt   = S_FIND;
        end
        PH_B: begin
          if (ra_r == rt) begin
            phase_nxt   = PH_Z;
            cur_nxt     = '0;
            walkv_nxt   = '0;
            req.p_re    = 1'b1;
            req.p_raddr = '0;
            state_nxt   = S_FIND;
          end else begin
            eq_nxt = (rka_r == rk);
            if (rka_r < rk) begin
              win_nxt  = rt;
              wrk_nxt  = rk;
              lose_nxt = ra_r;
              lrk_nxt  = rka_r;
            end else begin
              win_nxt  = ra_r;
              wrk_nxt  = rka_r;
              lose_nxt = rt;
              lrk_nxt  = rk;
            end
            state_nxt = S_UNI0;
          end
        end
        default: begin
          root_nxt  = rt;
          state_nxt = S_RDW;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      phase_r <= PH_A;
      clr_r   <= '0;
      vc_r    <= ufst_pkg::COUNT_MAX;
      total_r <= ufst_pkg::COUNT_MAX;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      clr_r   <= clr_nxt;
      vc_r    <= vc_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    walkv_r  <= walkv_nxt;
    root_r   <= root_nxt;
    rootrk_r <= rootrk_nxt;
    ra_r     <= ra_nxt;
    rka_r    <= rka_nxt;
    win_r    <= win_nxt;
    lose_r   <= lose_nxt;
    wrk_r    <= wrk_nxt;
    lrk_r    <= lrk_nxt;
    eq_r     <= eq_nxt;
    acc_r    <= acc_nxt;
    item_r   <= item_nxt;
    joined_r <= joined_nxt;
    bad_r    <= bad_nxt;
    oi_r     <= oi_nxt;
  end

endmodule

@@ sv/ufst_checker.sv @@
// ----------------------------------------------------------------------------
// ufst_checker
// Port-level checks on the union-find spanning tree block.
// ----------------------------------------------------------------------------
module ufst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input ufst_pkg::out_item_t out_item
);

  // reset starts the clearing sweep
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // an accepted command raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted command");

  // the result strobe lasts one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a rejected edge never joins
  a_bad_nojoin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bad_vertex) |-> !out_item.joined)
    else $error("joined set on a bad vertex");

  // component count stays in range
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.components_left != '0) &&
                  (out_item.components_left <= ufst_pkg::COUNT_MAX))
    else $error("components_left out of range");

endmodule

bind union_find_spanning_tree_top ufst_checker u_ufst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ dv/union_find_spanning_tree_top_test.sv @@
// ----------------------------------------------------------------------------
// union_find_spanning_tree_top_test
// Drives weighted edges into the union-find spanning tree block under several
// vertex counts, predicts every result with an independent union-find store
// and compares each result strobe field by field.
// ----------------------------------------------------------------------------
module union_find_spanning_tree_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 128;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  ufst_pkg::in_item_t   in_item;
  logic                 out_valid;
  ufst_pkg::out_item_t  out_item;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  union_find_spanning_tree_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predicted union-find store
  ufst_pkg::vidx_t     uf_parent [ufst_pkg::MAX_VERTICES];
  ufst_pkg::rank_t     uf_rank   [ufst_pkg::MAX_VERTICES];
  ufst_pkg::wgt_t      uf_weight [ufst_pkg::MAX_VERTICES];
  int                  uf_count;
  int                  uf_total;
  ufst_pkg::out_item_t expected_results[$];
  int                  mismatches;
  int                  edge_base;

  function automatic void clear_forest();
    for (int i = 0; i < ufst_pkg::MAX_VERTICES; i++) begin
      uf_parent[i] = ufst_pkg::vidx_t'(i);
      uf_rank[i]   = ufst_pkg::RANK_INIT;
      uf_weight[i] = '0;
    end
    uf_total = uf_count;
  endfunction

  // walk to the root, then point every visited vertex straight at it
  function automatic ufst_pkg::vidx_t find_root(ufst_pkg::vidx_t v);
    ufst_pkg::vidx_t root;
    ufst_pkg::vidx_t cur;
    ufst_pkg::vidx_t nxt;
    int              steps;
    root  = v;
    steps = 0;
    while (uf_parent[root] != root && steps < uf_count) begin
      root = uf_parent[root];
      steps++;
    end
    cur   = v;
    steps = 0;
    while (cur != root && steps < uf_count) begin
      nxt            = uf_parent[cur];
      uf_parent[cur] = root;
      cur            = nxt;
      steps++;
    end
    return root;
  endfunction

  // apply one edge to the store and queue the tree state it leaves
  function automatic void join_edge(ufst_pkg::in_item_t it);
    ufst_pkg::out_item_t r;
    ufst_pkg::vidx_t     ra;
    ufst_pkg::vidx_t     rb;
    ufst_pkg::vidx_t     win;
    ufst_pkg::vidx_t     lose;
    ufst_pkg::wgt_t      w;
    w = {{32{it.edge_weight[31]}}, it.edge_weight};
    r = '0;
    if (int'(it.vertex_a) >= uf_count || int'(it.vertex_b) >= uf_count) begin
      r.bad_vertex = 1'b1;
    end else begin
      ra = find_root(it.vertex_a);
      rb = find_root(it.vertex_b);
      if (ra != rb) begin
        if (uf_rank[ra] == uf_rank[rb]) begin
          win  = ra;
          lose = rb;
          if (uf_rank[win] < ufst_pkg::RANK_LIMIT) uf_rank[win] = uf_rank[win] + 1'b1;
        end else if (uf_rank[ra] < uf_rank[rb]) begin
          win  = rb;
          lose = ra;
        end else begin
          win  = ra;
          lose = rb;
        end
        uf_parent[lose] = win;
        uf_weight[win]  = uf_weight[win] + w + uf_weight[lose];
        if (uf_total > 1) uf_total--;
        r.joined = 1'b1;
      end
    end
    r.components_left = ufst_pkg::cnt_t'(uf_total);
    r.tree_weight     = uf_weight[find_root('0)];
    expected_results.push_back(r);
  endfunction

  // compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    ufst_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", out_item);
      end else begin
        e = expected_results.pop_front();
        if (out_item.joined !== e.joined || out_item.bad_vertex !== e.bad_vertex ||
            out_item.components_left !== e.components_left ||
            out_item.tree_weight !== e.tree_weight) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: joined %b/%b bad %b/%b comps %0d/%0d weight %0d/%0d (exp/act)",
                     e.joined, out_item.joined, e.bad_vertex, out_item.bad_vertex,
                     e.components_left, out_item.components_left,
                     e.tree_weight, out_item.tree_weight);
        end
      end
    end
  end

  // send one edge: random gap, then hold start until busy drops after the result
  task automatic send_edge(input ufst_pkg::vidx_t a, input ufst_pkg::vidx_t b,
                           input logic [31:0] w);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start               <= 1'b1;
    in_item.vertex_a    <= a;
    in_item.vertex_b    <= b;
    in_item.edge_weight <= w;
    do @(posedge clk); while (busy);
    join_edge('{vertex_a: a, vertex_b: b, edge_weight: w});
  endtask

  // wait for idle, then write vertex_count over the two-phase port
  task automatic write_vertex_count(input logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ufst_pkg::REG_VERTEX_COUNT, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    uf_count = value[10:0] == 0 ? 1 :
               (value[10:0] > ufst_pkg::MAX_VERTICES ? ufst_pkg::MAX_VERTICES :
                int'(value[10:0]));
    clear_forest();
    repeat (2) @(posedge clk);
  endtask

  // extremes, self loops, repeated joins and the weight limits
  task automatic test_directed();
    send_edge(10'd0, 10'd1023, 32'h7FFF_FFFF);
    send_edge(10'd0, 10'd0, 32'h8000_0000);
    send_edge(10'd1023, 10'd0, 32'h0000_0001);
    send_edge(10'd1, 10'd2, 32'h8000_0000);
    send_edge(10'd2, 10'd0, 32'hFFFF_FFFF);
    send_edge(10'd3, 10'd4, 32'h7FFF_FFFF);
    send_edge(10'd4, 10'd1, 32'h7FFF_FFFF);
    send_edge(10'd1, 10'd3, 32'h0000_0000);
    send_edge(10'd5, 10'd5, 32'h1234_5678);
    send_edge(10'd682, 10'd341, 32'hAAAA_AAAA);
    send_edge(10'd341, 10'd0, 32'h5555_5555);
  endtask

  // single vertex, where every other index is out of range, then four vertices
  task automatic test_bad_vertex();
    write_vertex_count(32'd0);
    send_edge(10'd0, 10'd0, 32'd7);
    send_edge(10'd1, 10'd0, 32'd8);
    send_edge(10'd0, 10'd1023, 32'd9);
    write_vertex_count(32'd4);
    send_edge(10'd3, 10'd2, 32'd1);
    send_edge(10'd4, 10'd3, 32'd2);
    send_edge(10'd0, 10'd2, 32'd3);
    send_edge(10'd1, 10'd3, 32'd4);
    send_edge(10'd0, 10'd1, 32'd5);
  endtask

  // mostly sorted in-range edges, some noise with full random fields
  task automatic test_random_phase(input logic [31:0] count_value, input int n);
    int              vmax;
    ufst_pkg::vidx_t a;
    ufst_pkg::vidx_t b;
    write_vertex_count(count_value);
    vmax      = uf_count - 1;
    edge_base = int'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        a = ufst_pkg::vidx_t'($urandom_range(0, vmax));
        b = ufst_pkg::vidx_t'($urandom_range(0, vmax));
        edge_base = edge_base + int'($urandom_range(0, 1000));
        send_edge(a, b, edge_base);
      end else begin
        send_edge(ufst_pkg::vidx_t'($urandom), ufst_pkg::vidx_t'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    uf_count   = ufst_pkg::MAX_VERTICES;
    clear_forest();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_bad_vertex();
    test_random_phase(32'd2, 150);
    test_random_phase(32'd16, 300);
    test_random_phase(32'd64, 300);
    test_random_phase(32'hFFFF_F7FF, 250);
    test_random_phase(32'd1024, 200);
    test_random_phase($urandom_range(1, 1024), 150);
    test_random_phase(32'd100, 180);

    start <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ufst_pkg.sv
sv/ufst_store.sv
sv/ufst_seq.sv
sv/union_find_spanning_tree_top.sv
sv/ufst_checker.sv
dv/union_find_spanning_tree_top_test.sv
